// File: hw/rtl/prle_pkg.sv
`default_nettype none

package prle_pkg;

  // depth of the job queue between front and back (power of two)
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // number of run codes carried by one job
  localparam logic [1:0] NCODE_NONE = 2'd0;
  localparam logic [1:0] NCODE_ONE  = 2'd1;
  localparam logic [1:0] NCODE_TWO  = 2'd2;

  // one classified pixel, as handed from front to back
  typedef struct packed {
    logic [1:0]  n_codes;
    logic [7:0]  code0;
    logic [7:0]  code1;
    logic        added;
    logic [3:0]  add_idx;
    logic [15:0] add_color;
    logic        too_many;
    logic        last;
  } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/prle_front.sv
`default_nettype none

module prle_front import prle_pkg::*; #(
  parameter int PALETTE_SIZE = 16,
  parameter int MAX_RUN      = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       last_pixel_i,
  output job_t            job_o
);

  localparam int CW = $clog2(PALETTE_SIZE + 1);
  localparam int IW = $clog2(PALETTE_SIZE);
  localparam logic [CW-1:0] PsCount = CW'(PALETTE_SIZE);
  localparam logic [4:0]    MaxRun  = 5'(MAX_RUN);

  logic [15:0]   pal_q [PALETTE_SIZE];
  logic [CW-1:0] count_q, count_d;
  logic [3:0]    run_idx_q, run_idx_d;
  logic [3:0]    run_len_q, run_len_d;
  logic          run_act_q, run_act_d;
  logic          err_q, err_d;

  logic [15:0] color;
  logic        hit;
  logic [3:0]  hit_idx;
  logic        room;
  logic        have;
  logic        add;
  logic [3:0]  pidx;
  logic        cont;
  logic        emit_old;
  logic        emit_new;
  logic [7:0]  old_code;
  logic [7:0]  new_code;

  assign color = {red_i[7:3], green_i[7:2], blue_i[7:3]};

  // parallel compare against the filled slots, lowest slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = 4'd0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      if (!hit && (CW'(i) < count_q) && (pal_q[i] == color)) begin
        hit     = 1'b1;
        hit_idx = 4'(i);
      end
    end
  end

  assign room     = count_q < PsCount;
  assign have     = !err_q && (hit || room);
  assign add      = !err_q && !hit && room;
  assign pidx     = hit ? hit_idx : 4'(count_q);
  assign old_code = {run_idx_q, run_len_q};
  assign cont     = run_act_q && (run_idx_q == pidx) && (({1'b0, run_len_q} + 5'd1) < MaxRun);

  always_comb begin
    run_idx_d = run_idx_q;
    run_len_d = run_len_q;
    run_act_d = run_act_q;
    emit_old  = 1'b0;
    emit_new  = 1'b0;
    new_code  = 8'd0;
    if (have) begin
      if (cont) begin
        run_len_d = run_len_q + 4'd1;
      end else begin
        emit_old  = run_act_q;
        run_idx_d = pidx;
        run_len_d = 4'd0;
        run_act_d = 1'b1;
      end
      emit_new = last_pixel_i || (({1'b0, run_len_d} + 5'd1) >= MaxRun);
      new_code = {run_idx_d, run_len_d};
      if (emit_new) begin
        run_act_d = 1'b0;
        run_len_d = 4'd0;
      end
    end else if (last_pixel_i && run_act_q) begin
      emit_old  = 1'b1;
      run_act_d = 1'b0;
    end
    err_d   = err_q || (!hit && !room);
    count_d = count_q + CW'(add);
  end

  always_comb begin
    job_o.n_codes   = NCODE_NONE;
    job_o.code0     = new_code;
    job_o.code1     = 8'd0;
    if (emit_old) begin
      job_o.code0   = old_code;
      job_o.code1   = new_code;
      job_o.n_codes = emit_new ? NCODE_TWO : NCODE_ONE;
    end else if (emit_new) begin
      job_o.n_codes = NCODE_ONE;
    end
    job_o.added     = add;
    job_o.add_idx   = pidx;
    job_o.add_color = color;
    job_o.too_many  = err_d;
    job_o.last      = last_pixel_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && add) begin
      pal_q[count_q[IW-1:0]] <= color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      run_idx_q <= 4'd0;
      run_len_q <= 4'd0;
      run_act_q <= 1'b0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      if (last_pixel_i) begin
        count_q   <= '0;
        run_idx_q <= 4'd0;
        run_len_q <= 4'd0;
        run_act_q <= 1'b0;
        err_q     <= 1'b0;
      end else begin
        count_q   <= count_d;
        run_idx_q <= run_idx_d;
        run_len_q <= run_len_d;
        run_act_q <= run_act_d;
        err_q     <= err_d;
      end
    end
  end

  // an open run is always shorter than the max run
  a_run_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_act_q |-> (({1'b0, run_len_q} + 5'd1) < MaxRun))
    else $error("open run reached max length");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PsCount)
    else $error("palette count overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_pixel_i) |=> (count_q == '0) && !run_act_q && !err_q)
    else $error("state not cleared after last pixel");

endmodule

`default_nettype wire

// File: hw/rtl/prle_queue.sv
`default_nettype none

module prle_queue import prle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire job_t wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output logic      avail_o,
  output job_t      rd_data_o
);

  job_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QCW-1:0] cnt_q;
  logic           do_wr;
  logic           do_rd;

  assign full_o    = cnt_q == QCW'(QDEPTH);
  assign avail_o   = cnt_q != '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && avail_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      cnt_q <= cnt_q + QCW'(do_wr) - QCW'(do_rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QDEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

  a_rd_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_rd) |=> full_o)
    else $error("full queue drained without read");

endmodule

`default_nettype wire

// File: hw/rtl/prle_back.sv
`default_nettype none

module prle_back import prle_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  wire job_t   head_i,
  output logic        head_take_o,
  output logic        empty,
  input  wire logic   pop,
  output logic        code_valid_o,
  output logic [7:0]  run_code_o,
  output logic        color_added_o,
  output logic [3:0]  color_index_o,
  output logic [15:0] color_value_o,
  output logic        too_many_colors_o,
  output logic        image_done_o,
  output logic        last_of_item_o
);

  logic phase_q;
  logic out_vld_q;
  logic pop_ok;
  logic load;
  logic final_sel;
  logic any_code;

  logic        cv_q;
  logic [7:0]  code_q;
  logic        added_q;
  logic [3:0]  idx_q;
  logic [15:0] val_q;
  logic        err_q;
  logic        done_q;
  logic        lst_q;

  assign pop_ok      = pop && out_vld_q;
  assign load        = head_valid_i && (!out_vld_q || pop_ok);
  assign final_sel   = phase_q || (head_i.n_codes != NCODE_TWO);
  assign any_code    = head_i.n_codes != NCODE_NONE;
  assign head_take_o = load && final_sel;

  // second word of a two-code job carries code1 only
  always_ff @(posedge clk_i) begin
    if (load) begin
      cv_q    <= phase_q || any_code;
      code_q  <= phase_q ? head_i.code1 : (any_code ? head_i.code0 : 8'd0);
      added_q <= !phase_q && head_i.added;
      idx_q   <= (!phase_q && head_i.added) ? head_i.add_idx : 4'd0;
      val_q   <= (!phase_q && head_i.added) ? head_i.add_color : 16'd0;
      err_q   <= head_i.too_many;
      done_q  <= head_i.last && final_sel;
      lst_q   <= final_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        phase_q   <= !final_sel;
      end else if (pop_ok) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty             = !out_vld_q;
  assign code_valid_o      = cv_q;
  assign run_code_o        = code_q;
  assign color_added_o     = added_q;
  assign color_index_o     = idx_q;
  assign color_value_o     = val_q;
  assign too_many_colors_o = err_q;
  assign image_done_o      = done_q;
  assign last_of_item_o    = lst_q;

  // a word that is not the last of its item always carries a code
  a_mid_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !lst_q) |-> cv_q)
    else $error("non-final word without code");

  // the second word follows at once and never reports a color
  a_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !lst_q) |=> out_vld_q && cv_q && !added_q)
    else $error("second word of item missing or malformed");

  a_done_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && done_q) |-> lst_q)
    else $error("image done on non-final word");

endmodule

`default_nettype wire

// File: hw/rtl/palette_rle_pixel_encoder_core.sv
`default_nettype none

// channel   direction  handshake           payload
// pixel     in         push / full         red_i green_i blue_i last_pixel_i
// result    out        empty / pop         code_valid_o run_code_o color_added_o
//                                          color_index_o color_value_o
//                                          too_many_colors_o image_done_o last_of_item_o
//
// one pixel is taken per cycle while the queue is not full; palette lookup and run update finish in the accept cycle
// the back end sends one result word per cycle while pop takes them, so a pixel that yields two words holds
// the back end for both of its words while a 4-job queue keeps the front taking pixels
// first word of a pixel is written into the queue, then loaded into the back end's output register
// rst_ni clears counts, run and error state at once; palette slots are not cleared
// full rises only when the job queue fills; result stalls never block the front directly

module palette_rle_pixel_encoder_core import prle_pkg::*; #(
  parameter int PALETTE_SIZE = 16,
  parameter int MAX_RUN      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic        last_pixel_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             code_valid_o,
  output logic [7:0]       run_code_o,
  output logic             color_added_o,
  output logic [3:0]       color_index_o,
  output logic [15:0]      color_value_o,
  output logic             too_many_colors_o,
  output logic             image_done_o,
  output logic             last_of_item_o
);

  // pixel word accepted into the front
  logic accept;
  // job from front into the queue
  job_t job;
  // head of queue toward the back
  job_t head;
  logic head_valid;
  logic head_take;
  logic q_full;

  assign accept = push && !q_full;
  assign full   = q_full;

  // front: palette lookup, color insertion, run-length update
  prle_front #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .MAX_RUN      (MAX_RUN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .job_o        (job)
  );

  // decoupling queue of classified pixels
  prle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (job),
    .full_o    (q_full),
    .rd_i      (head_take),
    .avail_o   (head_valid),
    .rd_data_o (head)
  );

  // back: expands each job into one or two result words
  prle_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .head_take_o       (head_take),
    .empty             (empty),
    .pop               (pop),
    .code_valid_o      (code_valid_o),
    .run_code_o        (run_code_o),
    .color_added_o     (color_added_o),
    .color_index_o     (color_index_o),
    .color_value_o     (color_value_o),
    .too_many_colors_o (too_many_colors_o),
    .image_done_o      (image_done_o),
    .last_of_item_o    (last_of_item_o)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_SLOTS   = 16;
  localparam int RUN_LIMIT   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // one result word as it leaves the block
  typedef struct packed {
    bit        code_valid;
    bit [7:0]  run_code;
    bit        color_added;
    bit [3:0]  color_index;
    bit [15:0] color_value;
    bit        too_many;
    bit        image_done;
    bit        last_of_item;
  } code_word_t;

  // directed stimulus row, with an optional hand-written result word
  typedef struct packed {
    bit [7:0]   red;
    bit [7:0]   green;
    bit [7:0]   blue;
    bit         last;
    bit         typed;
    code_word_t want;
  } pixel_row_t;

  // words that can be read straight off the encoding rules
  localparam code_word_t LONE_WHITE    = '{1'b1, 8'h00, 1'b1, 4'd0, 16'hFFFF, 1'b0, 1'b1, 1'b1};
  localparam code_word_t LONE_BLACK    = '{1'b1, 8'h00, 1'b1, 4'd0, 16'h0000, 1'b0, 1'b1, 1'b1};
  localparam code_word_t IGNORED_PIXEL = '{1'b0, 8'h00, 1'b0, 4'd0, 16'h0000, 1'b1, 1'b0, 1'b1};
  localparam code_word_t ERROR_FLUSH   = '{1'b1, 8'hF0, 1'b0, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b1};

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic [7:0] red_i        = 8'd0;
  logic [7:0] green_i      = 8'd0;
  logic [7:0] blue_i       = 8'd0;
  logic       last_pixel_i = 1'b0;
  logic       empty;
  logic       pop          = 1'b0;
  logic       code_valid_o;
  logic [7:0] run_code_o;
  logic       color_added_o;
  logic [3:0] color_index_o;
  logic [15:0] color_value_o;
  logic       too_many_colors_o;
  logic       image_done_o;
  logic       last_of_item_o;

  palette_rle_pixel_encoder_core #(
    .PALETTE_SIZE(PAL_SLOTS),
    .MAX_RUN     (RUN_LIMIT)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .last_pixel_i     (last_pixel_i),
    .empty            (empty),
    .pop              (pop),
    .code_valid_o     (code_valid_o),
    .run_code_o       (run_code_o),
    .color_added_o    (color_added_o),
    .color_index_o    (color_index_o),
    .color_value_o    (color_value_o),
    .too_many_colors_o(too_many_colors_o),
    .image_done_o     (image_done_o),
    .last_of_item_o   (last_of_item_o)
  );

  always #4 clk_i = ~clk_i;

  // encoder model state
  bit [15:0] palette [PAL_SLOTS];
  int        palette_used;
  bit [3:0]  run_idx;
  bit [3:0]  run_len_m1;
  bit        run_open;
  bit        palette_overflow;

  code_word_t code_words_due[$];
  pixel_row_t directed_rows[$];

  // set by the sender along with the pixel, read at the accepting edge
  bit         row_is_typed;
  code_word_t row_word;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int useful_pixels;
  int images_closed;
  int overflow_images;
  int full_run_codes;
  int words_checked;
  int mismatch_count;
  int cycle_count;

  // reduce to rgb565, look up or grow the palette, advance the run
  task automatic encode_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                              input bit last);
    bit [15:0]  shade;
    bit [7:0]   codes [2];
    int         n_codes;
    int         n_words;
    bit         added;
    bit         have;
    bit         found;
    bit [3:0]   idx;
    code_word_t w;
    shade   = {r[7:3], g[7:2], b[7:3]};
    n_codes = 0;
    added   = 1'b0;
    have    = 1'b0;
    found   = 1'b0;
    idx     = 4'd0;
    if (!palette_overflow) begin
      useful_pixels++;
      for (int i = 0; i < palette_used; i++) begin
        if (!found && palette[i] == shade) begin
          found = 1'b1;
          idx   = 4'(i);
        end
      end
      if (found) begin
        have = 1'b1;
      end else if (palette_used < PAL_SLOTS) begin
        // new color goes in the next free slot
        idx          = 4'(palette_used);
        palette[idx] = shade;
        palette_used++;
        added = 1'b1;
        have  = 1'b1;
      end else begin
        // one color too many: flag sticks until the image closes
        palette_overflow = 1'b1;
        overflow_images++;
      end
    end else if (last) begin
      useful_pixels++;
    end

    if (have) begin
      if (run_open && run_idx == idx && run_len_m1 != 4'(RUN_LIMIT - 1)) begin
        run_len_m1++;
      end else begin
        if (run_open) begin
          codes[n_codes] = {run_idx, run_len_m1};
          n_codes++;
        end
        run_idx    = idx;
        run_len_m1 = 4'd0;
        run_open   = 1'b1;
      end
      if (last || run_len_m1 == 4'(RUN_LIMIT - 1)) begin
        if (run_len_m1 == 4'(RUN_LIMIT - 1)) full_run_codes++;
        codes[n_codes] = {run_idx, run_len_m1};
        n_codes++;
        run_open   = 1'b0;
        run_len_m1 = 4'd0;
      end
    end else if (last && run_open) begin
      // run opened before the overflow still gets flushed
      codes[n_codes] = {run_idx, run_len_m1};
      n_codes++;
      run_open = 1'b0;
    end

    n_words = (n_codes > 0) ? n_codes : 1;
    for (int k = 0; k < n_words; k++) begin
      w = '0;
      if (k < n_codes) begin
        w.code_valid = 1'b1;
        w.run_code   = codes[k];
      end
      if (k == 0 && added) begin
        w.color_added = 1'b1;
        w.color_index = idx;
        w.color_value = shade;
      end
      w.too_many     = palette_overflow;
      w.last_of_item = (k == n_words - 1);
      w.image_done   = last && w.last_of_item;
      code_words_due.push_back(w);
    end

    if (last) begin
      palette_used     = 0;
      run_idx          = 4'd0;
      run_len_m1       = 4'd0;
      run_open         = 1'b0;
      palette_overflow = 1'b0;
      images_closed++;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // accepted pixels feed the model, accepted words are checked in order
  always @(posedge clk_i) begin
    code_word_t want;
    if (rst_ni) begin
      if (push && !full) begin
        encode_pixel(red_i, green_i, blue_i, last_pixel_i);
        if (row_is_typed) begin
          // hand-written word takes the place of the modeled one
          void'(code_words_due.pop_back());
          code_words_due.push_back(row_word);
        end
      end
      if (pop && !empty) begin
        words_checked++;
        if (code_words_due.size() == 0) begin
          $error("result word arrived with none expected");
          mismatch_count++;
        end else begin
          want = code_words_due.pop_front();
          check_field("code_valid", want.code_valid, code_valid_o);
          check_field("run_code", want.run_code, run_code_o);
          check_field("color_added", want.color_added, color_added_o);
          check_field("color_index", want.color_index, color_index_o);
          check_field("color_value", want.color_value, color_value_o);
          check_field("too_many_colors", want.too_many, too_many_colors_o);
          check_field("image_done", want.image_done, image_done_o);
          check_field("last_of_item", want.last_of_item, last_of_item_o);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off while the queue backs up
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      pop = 1'b0;
      hold_off_cycles--;
    end else begin
      pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one pixel from a falling edge, return at the falling edge after acceptance
  task automatic send_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                            input bit last, input bit typed = 1'b0,
                            input code_word_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push         = 1'b1;
    red_i        = r;
    green_i      = g;
    blue_i       = b;
    last_pixel_i = last;
    row_is_typed = typed;
    row_word     = want;
    do begin
      @(posedge clk_i);
    end while (full);
    @(negedge clk_i);
  endtask

  // widen a 565 color back to 888 with random low bits
  task automatic send_shade(input bit [15:0] c, input bit last);
    send_pixel({c[15:11], 3'($urandom)}, {c[10:5], 2'($urandom)},
               {c[4:0], 3'($urandom)}, last);
  endtask

  // one image: mostly runs over a small palette, some overflow and noise images
  task automatic send_image();
    bit [15:0] shades [20];
    int        n_shades;
    int        n_pix;
    int        sent;
    int        pick;
    int        run;
    int        roll;
    int        run_roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      // noise: unrelated pixels, overflow likely on longer images
      n_pix = $urandom_range(24, 1);
      for (int k = 0; k < n_pix; k++) begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), k == n_pix - 1);
      end
    end else begin
      n_shades = (roll < 20) ? $urandom_range(20, PAL_SLOTS + 1) : $urandom_range(PAL_SLOTS, 1);
      for (int i = 0; i < n_shades; i++) begin
        bit dup;
        do begin
          shades[i] = 16'($urandom);
          dup = 1'b0;
          for (int j = 0; j < i; j++) begin
            if (shades[j] == shades[i]) dup = 1'b1;
          end
        end while (dup);
      end
      if (n_shades > PAL_SLOTS) begin
        // walk the colors in order until the palette overflows, then a short tail
        for (int i = 0; i < n_shades; i++) begin
          repeat ($urandom_range(3, 1)) send_shade(shades[i], 1'b0);
        end
        repeat ($urandom_range(3, 0)) send_shade(shades[$urandom_range(n_shades - 1)], 1'b0);
        send_shade(shades[$urandom_range(n_shades - 1)], 1'b1);
      end else begin
        n_pix = ($urandom_range(9) == 0) ? 1 : $urandom_range(48, 2);
        sent  = 0;
        while (sent < n_pix) begin
          pick     = $urandom_range(n_shades - 1);
          run_roll = $urandom_range(99);
          if (run_roll < 70) begin
            run = $urandom_range(4, 1);
          end else if (run_roll < 85) begin
            // right at and just past the longest run
            run = RUN_LIMIT + $urandom_range(1);
          end else begin
            run = $urandom_range(40, 5);
          end
          for (int k = 0; k < run && sent < n_pix; k++) begin
            sent++;
            send_shade(shades[pick], sent == n_pix);
          end
        end
      end
    end
  endtask

  initial begin
    int goal;
    int idle_pct [4];
    int stall_pct[4];
    idle_pct  = '{0, 72, 0, 26};
    stall_pct = '{0, 0, 72, 26};

    // single-pixel images at the color extremes
    directed_rows.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, LONE_WHITE});
    directed_rows.push_back('{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, LONE_BLACK});
    // short image: a run across two shades that reduce to the same color,
    // color changes, and a color change on the last pixel
    directed_rows.push_back('{8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, code_word_t'('0)});
    directed_rows.push_back('{8'hF8, 8'h03, 8'h07, 1'b0, 1'b0, code_word_t'('0)});
    directed_rows.push_back('{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, code_word_t'('0)});
    directed_rows.push_back('{8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, code_word_t'('0)});
    directed_rows.push_back('{8'h00, 8'hFC, 8'h00, 1'b0, 1'b0, code_word_t'('0)});
    directed_rows.push_back('{8'h80, 8'h80, 8'h80, 1'b1, 1'b0, code_word_t'('0)});
    // fill all sixteen slots, then overflow, ignored pixel, flush while in error
    for (int i = 0; i < PAL_SLOTS; i++) begin
      directed_rows.push_back('{8'(i * 16), 8'(255 - i * 16), 8'(i * 8), 1'b0, 1'b0,
                                code_word_t'('0)});
    end
    directed_rows.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, IGNORED_PIXEL});
    directed_rows.push_back('{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, IGNORED_PIXEL});
    directed_rows.push_back('{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, ERROR_FLUSH});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[n]) begin
      send_pixel(directed_rows[n].red, directed_rows[n].green, directed_rows[n].blue,
                 directed_rows[n].last, directed_rows[n].typed, directed_rows[n].want);
    end

    // random images in four idling phases, first one opens with a long pop hold-off
    goal = useful_pixels;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) hold_off_cycles = 300;
      goal += 300;
      while (useful_pixels < goal) send_image();
    end
    push = 1'b0;

    while (code_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("encoded %0d images from %0d counted pixels, %0d result words checked",
             images_closed, useful_pixels, words_checked);
    $display("palette overflows: %0d, codes closed at the longest run: %0d",
             overflow_images, full_run_codes);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
